@@ rtl/core/u8d_pkg.sv @@
package u8d_pkg;

  localparam int unsigned CpW = 21;

  localparam logic [7:0] ContBase  = 8'h80;
  localparam logic [7:0] Lead2Base = 8'hC0;
  localparam logic [7:0] Lead3Base = 8'hE0;
  localparam logic [7:0] Lead4Base = 8'hF0;
  localparam logic [7:0] BadLead   = 8'hF8;
  localparam logic [7:0] ContMask  = 8'hC0;
  localparam logic [7:0] Lead2Mask = 8'h1F;
  localparam logic [7:0] Lead3Mask = 8'h0F;
  localparam logic [7:0] Lead4Mask = 8'h07;
  localparam logic [7:0] PayMask   = 8'h3F;
  localparam logic [CpW-1:0] MapOffset = 21'h00D800;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       last_byte;
  } byte_beat_t;

  typedef struct packed {
    logic [CpW-1:0] code_point;
    logic           point_valid;
    logic           bad_input;
    logic           string_end;
  } point_beat_t;

endpackage

@@ rtl/core/u8d_if.sv @@
interface u8d_byte_if;
  import u8d_pkg::*;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       last_byte;

  modport source (output valid, output in_byte, output last_byte, input ready);
  modport sink   (input valid, input in_byte, input last_byte, output ready);
endinterface

interface u8d_point_if;
  import u8d_pkg::*;
  logic           valid;
  logic           ready;
  logic [CpW-1:0] code_point;
  logic           point_valid;
  logic           bad_input;
  logic           string_end;

  modport source (output valid, output code_point, output point_valid,
                  output bad_input, output string_end, input ready);
  modport sink   (input valid, input code_point, input point_valid,
                  input bad_input, input string_end, output ready);
endinterface

@@ rtl/core/u8d_decode.sv @@
module u8d_decode
  import u8d_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        map_non_symbol,
  input  byte_beat_t  beat,
  input  logic        advance,
  output logic        emit,
  output point_beat_t result
);

  logic [1:0]     bytes_owed;
  logic [CpW-1:0] partial_point;
  logic           error_seen;

  logic [1:0]     bytes_owed_next;
  logic [CpW-1:0] partial_point_next;
  logic           error_seen_next;

  logic [7:0]     b;
  logic           last;
  logic           fail;
  logic           done;
  logic           is_symbol;
  logic [CpW-1:0] cp;
  logic [CpW-1:0] joined;
  logic [1:0]     owed_dec;

  assign b        = beat.in_byte;
  assign last     = beat.last_byte;
  assign joined   = {partial_point[CpW-7:0], b[5:0] & PayMask[5:0]};
  assign owed_dec = bytes_owed - 2'd1;

  always_comb begin
    is_symbol = (b inside {[8'h61:8'h7A], [8'h41:8'h5A], [8'h30:8'h39], 8'h24, 8'h5F});
  end

  always_comb begin
    bytes_owed_next    = bytes_owed;
    partial_point_next = partial_point;
    error_seen_next    = error_seen;
    fail   = 1'b0;
    done   = 1'b0;
    cp     = '0;
    emit   = 1'b0;
    result = '0;

    if (error_seen) begin
      if (last) begin
        error_seen_next    = 1'b0;
        bytes_owed_next    = '0;
        partial_point_next = '0;
        emit               = 1'b1;
        result.string_end  = 1'b1;
      end
    end else begin
      if (bytes_owed == 2'd0) begin
        if (b < ContBase) begin
          cp   = (map_non_symbol && !is_symbol) ? ({13'd0, b} + MapOffset)
                                                : {13'd0, b};
          done = 1'b1;
        end else if (b < Lead2Base) begin
          fail = 1'b1;
        end else if (b < Lead3Base) begin
          partial_point_next = {13'd0, b & Lead2Mask};
          bytes_owed_next    = 2'd1;
        end else if (b < Lead4Base) begin
          partial_point_next = {13'd0, b & Lead3Mask};
          bytes_owed_next    = 2'd2;
        end else if (b < BadLead) begin
          partial_point_next = {13'd0, b & Lead4Mask};
          bytes_owed_next    = 2'd3;
        end else begin
          fail = 1'b1;
        end
        if (!fail && !done && last) begin
          fail = 1'b1;
        end
      end else begin
        if ((b & ContMask) != ContBase) begin
          fail = 1'b1;
        end else begin
          bytes_owed_next = owed_dec;
          if (owed_dec == 2'd0) begin
            cp                 = joined;
            partial_point_next = '0;
            done               = 1'b1;
          end else begin
            partial_point_next = joined;
            if (last) begin
              fail = 1'b1;
            end
          end
        end
      end

      if (fail) begin
        bytes_owed_next    = '0;
        partial_point_next = '0;
        error_seen_next    = !last;
        emit               = 1'b1;
        result.bad_input   = 1'b1;
        result.string_end  = last;
      end else if (done) begin
        if (last) begin
          bytes_owed_next    = '0;
          partial_point_next = '0;
          error_seen_next    = 1'b0;
        end
        emit               = 1'b1;
        result.code_point  = cp;
        result.point_valid = 1'b1;
        result.string_end  = last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_owed    <= '0;
      partial_point <= '0;
      error_seen    <= 1'b0;
    end else if (advance) begin
      bytes_owed    <= bytes_owed_next;
      partial_point <= partial_point_next;
      error_seen    <= error_seen_next;
    end
  end

endmodule

@@ rtl/core/u8d_out_reg.sv @@
module u8d_out_reg
  import u8d_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  point_beat_t data,
  output logic        free,
  u8d_point_if.source points
);

  logic        held_valid;
  point_beat_t held;

  assign free = !held_valid || points.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (free) begin
      held_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load) begin
      held <= data;
    end
  end

  assign points.valid       = held_valid;
  assign points.code_point  = held.code_point;
  assign points.point_valid = held.point_valid;
  assign points.bad_input   = held.bad_input;
  assign points.string_end  = held.string_end;

endmodule

@@ rtl/core/utf8_to_codepoint_decoder_top.sv @@
// An accepted byte beat passes through the byte register, which feeds the decode logic, and then the result register.
// Throughput: one byte per cycle while the result side keeps up; a byte that
// yields no result moves on even when the output register is full.
// Reset (rst, synchronous): clears decode state, map_non_symbol and all valids.
module utf8_to_codepoint_decoder_top
  import u8d_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  u8d_byte_if.sink    bytes,
  u8d_point_if.source points
);

  logic        map_non_symbol;
  logic        stage_valid;
  byte_beat_t  stage;
  logic        emit;
  logic        out_free;
  logic        advance;
  point_beat_t result;

  assign advance     = stage_valid && (!emit || out_free);
  assign bytes.ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      map_non_symbol <= 1'b0;
    end else if (cfg_wr_en) begin
      map_non_symbol <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (bytes.ready) begin
      stage_valid <= bytes.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (bytes.ready && bytes.valid) begin
      stage.in_byte   <= bytes.in_byte;
      stage.last_byte <= bytes.last_byte;
    end
  end

  u8d_decode u_decode (
    .clk            (clk),
    .rst            (rst),
    .map_non_symbol (map_non_symbol),
    .beat           (stage),
    .advance        (advance),
    .emit           (emit),
    .result         (result)
  );

  u8d_out_reg u_out_reg (
    .clk    (clk),
    .rst    (rst),
    .load   (advance && emit),
    .data   (result),
    .free   (out_free),
    .points (points)
  );

endmodule

@@ tb/utf8_to_codepoint_decoder_top_test.sv @@
module utf8_to_codepoint_decoder_top_test;
  import u8d_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [7:0]  in_byte;
    logic        last_byte;
    bit          typed;
    point_beat_t want;
  } byte_row_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_wr_en;
  logic cfg_wr_data;

  u8d_byte_if  byte_ch ();
  u8d_point_if point_ch ();

  utf8_to_codepoint_decoder_top DUT (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .bytes       (byte_ch),
    .points      (point_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  logic [1:0]     owed_cnt;
  logic [CpW-1:0] partial_cp;
  logic           string_bad;
  logic           map_mode;

  point_beat_t    point_queue [$];
  logic           row_typed;
  point_beat_t    row_want;

  int mismatches   = 0;
  int live_bytes   = 0;
  int points_seen  = 0;
  int bad_seen     = 0;
  int map_hits     = 0;
  int burst_left   = 0;
  bit long_hold_req = 1'b0;

  byte_row_t byte_rows [26];

  function automatic bit is_word_char(input logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") ||
           (b >= "0" && b <= "9") || b == "$" || b == "_";
  endfunction

  function automatic void clear_string();
    owed_cnt   = '0;
    partial_cp = '0;
    string_bad = 1'b0;
  endfunction

  function automatic bit decode_step(input logic [7:0] b, input logic last,
                                     output point_beat_t res);
    bit             fail;
    bit             done;
    logic [CpW-1:0] cp;
    fail = 1'b0;
    done = 1'b0;
    cp   = '0;
    res  = '0;
    if (string_bad) begin
      if (last) begin
        clear_string();
        res.string_end = 1'b1;
        return 1'b1;
      end
      return 1'b0;
    end
    if (owed_cnt == 2'd0) begin
      if (b < ContBase) begin
        if (map_mode && !is_word_char(b)) begin
          cp = MapOffset + CpW'(b);
          map_hits++;
        end else begin
          cp = CpW'(b);
        end
        done = 1'b1;
      end else if (b < Lead2Base) begin
        fail = 1'b1;
      end else if (b < Lead3Base) begin
        partial_cp = CpW'(b & Lead2Mask);
        owed_cnt   = 2'd1;
      end else if (b < Lead4Base) begin
        partial_cp = CpW'(b & Lead3Mask);
        owed_cnt   = 2'd2;
      end else if (b < BadLead) begin
        partial_cp = CpW'(b & Lead4Mask);
        owed_cnt   = 2'd3;
      end else begin
        fail = 1'b1;
      end
      if (!fail && !done && last) fail = 1'b1;
    end else begin
      if ((b & ContMask) != ContBase) begin
        fail = 1'b1;
      end else begin
        partial_cp = {partial_cp[CpW-7:0], b[5:0]};
        owed_cnt   = owed_cnt - 2'd1;
        if (owed_cnt == 2'd0) begin
          cp         = partial_cp;
          partial_cp = '0;
          done       = 1'b1;
        end else if (last) begin
          fail = 1'b1;
        end
      end
    end
    if (fail) begin
      if (last) begin
        clear_string();
      end else begin
        owed_cnt   = '0;
        partial_cp = '0;
        string_bad = 1'b1;
      end
      res.bad_input  = 1'b1;
      res.string_end = last;
      return 1'b1;
    end
    if (done) begin
      if (last) clear_string();
      res.code_point  = cp;
      res.point_valid = 1'b1;
      res.string_end  = last;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic report_mismatch(input string what, input point_beat_t got,
                                 input point_beat_t want);
    mismatches++;
    $display("%0t %s: got cp=%06h pv=%0b bad=%0b end=%0b, want cp=%06h pv=%0b bad=%0b end=%0b",
             $time, what, got.code_point, got.point_valid, got.bad_input, got.string_end,
             want.code_point, want.point_valid, want.bad_input, want.string_end);
  endtask

  always @(posedge clk) begin
    point_beat_t res;
    point_beat_t got;
    point_beat_t want;
    if (rst) begin
      clear_string();
      map_mode = 1'b0;
    end else begin
      if (cfg_wr_en) map_mode = cfg_wr_data;
      if (byte_ch.valid && byte_ch.ready) begin
        if (!string_bad || byte_ch.last_byte) live_bytes++;
        if (decode_step(byte_ch.in_byte, byte_ch.last_byte, res) || row_typed) begin
          point_queue = {point_queue, (row_typed ? row_want : res)};
        end
      end
      if (point_ch.valid && point_ch.ready) begin
        got.code_point  = point_ch.code_point;
        got.point_valid = point_ch.point_valid;
        got.bad_input   = point_ch.bad_input;
        got.string_end  = point_ch.string_end;
        points_seen++;
        if (got.bad_input) bad_seen++;
        if (point_queue.size() == 0) begin
          report_mismatch("unexpected beat", got, '0);
        end else begin
          want = point_queue.pop_front();
          if (got.code_point !== want.code_point || got.point_valid !== want.point_valid ||
              got.bad_input !== want.bad_input || got.string_end !== want.string_end) begin
            report_mismatch("field mismatch", got, want);
          end
        end
      end
    end
  end

  initial begin
    int stretch_left;
    int mode;
    int hold_left;
    stretch_left = 0;
    mode         = 0;
    hold_left    = 0;
    point_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req && hold_left == 0) begin
        hold_left     = 400;
        long_hold_req = 1'b0;
      end
      if (stretch_left == 0) begin
        mode         = $urandom_range(0, 3);
        stretch_left = $urandom_range(8, 120);
      end
      stretch_left--;
      if (hold_left > 0) begin
        hold_left--;
        point_ch.ready <= 1'b0;
      end else begin
        case (mode)
          0: point_ch.ready <= 1'b1;
          1: point_ch.ready <= 1'($urandom_range(0, 1));
          2: point_ch.ready <= (stretch_left % 4 == 0);
          default: point_ch.ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last, input bit typed,
                           input point_beat_t want);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(1, 30);
      if (gap > 0) begin
        byte_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    byte_ch.valid     <= 1'b1;
    byte_ch.in_byte   <= b;
    byte_ch.last_byte <= last;
    row_typed         <= typed;
    row_want          <= want;
    do @(posedge clk); while (!byte_ch.ready);
  endtask

  task automatic wait_drained();
    byte_ch.valid <= 1'b0;
    burst_left = 0;
    while (point_queue.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_map(input logic value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  task automatic run_strings(input int target);
    logic [7:0] str [$];
    int kind;
    int nchars;
    int n;
    int pos;
    while (live_bytes < target) begin
      str.delete();
      kind = $urandom_range(0, 19);
      if (kind == 0) begin
        n = $urandom_range(1, 6);
        repeat (n) str = {str, 8'($urandom_range(0, 255))};
      end else begin
        nchars = $urandom_range(1, 6);
        repeat (nchars) begin
          n = $urandom_range(1, 4);
          case (n)
            1: str = {str, 8'($urandom_range(0, 127))};
            2: str = {str, Lead2Base | 8'($urandom_range(0, 31))};
            3: str = {str, Lead3Base | 8'($urandom_range(0, 15))};
            default: str = {str, Lead4Base | 8'($urandom_range(0, 7))};
          endcase
          repeat (n - 1) str = {str, ContBase | 8'($urandom_range(0, 63))};
        end
        if (kind == 1 && str.size() > 1) begin
          str.pop_back();
        end else if (kind == 2) begin
          pos      = $urandom_range(0, str.size() - 1);
          str[pos] = 8'($urandom_range(0, 255));
        end else if (kind == 3) begin
          pos = $urandom_range(0, str.size());
          str.insert(pos, 8'($urandom_range(0, 255)));
        end
      end
      foreach (str[i]) send_byte(str[i], (i == str.size() - 1), 1'b0, '0);
    end
  endtask

  initial begin
    rst               <= 1'b1;
    cfg_wr_en         <= 1'b0;
    cfg_wr_data       <= 1'b0;
    byte_ch.valid     <= 1'b0;
    byte_ch.in_byte   <= 8'h00;
    byte_ch.last_byte <= 1'b0;
    row_typed         <= 1'b0;
    row_want          <= '0;

    byte_rows = '{
      '{8'h00, 1'b0, 1'b1, {21'h000000, 1'b1, 1'b0, 1'b0}},
      '{8'h7F, 1'b1, 1'b1, {21'h00007F, 1'b1, 1'b0, 1'b1}},
      '{8'hC3, 1'b0, 1'b0, '0},
      '{8'hA9, 1'b1, 1'b0, '0},
      '{8'hE2, 1'b0, 1'b0, '0},
      '{8'h82, 1'b0, 1'b0, '0},
      '{8'hAC, 1'b0, 1'b0, '0},
      '{8'hF0, 1'b0, 1'b0, '0},
      '{8'h9F, 1'b0, 1'b0, '0},
      '{8'h98, 1'b0, 1'b0, '0},
      '{8'h80, 1'b1, 1'b0, '0},
      '{8'hF7, 1'b0, 1'b0, '0},
      '{8'hBF, 1'b0, 1'b0, '0},
      '{8'hBF, 1'b0, 1'b0, '0},
      '{8'hBF, 1'b0, 1'b0, '0},
      '{8'h80, 1'b0, 1'b1, {21'h000000, 1'b0, 1'b1, 1'b0}},
      '{8'h42, 1'b1, 1'b1, {21'h000000, 1'b0, 1'b0, 1'b1}},
      '{8'hF8, 1'b1, 1'b1, {21'h000000, 1'b0, 1'b1, 1'b1}},
      '{8'hFF, 1'b0, 1'b1, {21'h000000, 1'b0, 1'b1, 1'b0}},
      '{8'hFF, 1'b1, 1'b1, {21'h000000, 1'b0, 1'b0, 1'b1}},
      '{8'hC2, 1'b0, 1'b0, '0},
      '{8'h41, 1'b0, 1'b1, {21'h000000, 1'b0, 1'b1, 1'b0}},
      '{8'h00, 1'b1, 1'b1, {21'h000000, 1'b0, 1'b0, 1'b1}},
      '{8'hE0, 1'b1, 1'b1, {21'h000000, 1'b0, 1'b1, 1'b1}},
      '{8'hE1, 1'b0, 1'b0, '0},
      '{8'h80, 1'b1, 1'b1, {21'h000000, 1'b0, 1'b1, 1'b1}}
    };

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (byte_rows[i]) begin
      send_byte(byte_rows[i].in_byte, byte_rows[i].last_byte, byte_rows[i].typed,
                byte_rows[i].want);
    end

    wait_drained();
    write_map(1'b1);
    long_hold_req = 1'b1;
    run_strings(600);

    wait_drained();
    write_map(1'b0);
    run_strings(1150);

    wait_drained();
    write_map(1'b1);
    run_strings(1700);

    wait_drained();
    repeat (8) @(posedge clk);

    $display("decoded %0d bytes into %0d result beats, %0d of them malformed-string flags",
             live_bytes, points_seen, bad_seen);
    $display("mapping mode toggled on and off; %0d ASCII bytes came out remapped", map_hits);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("timeout with %0d beats still expected", point_queue.size());
    $display("FAILURE");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/u8d_pkg.sv
rtl/core/u8d_if.sv
rtl/core/u8d_decode.sv
rtl/core/u8d_out_reg.sv
rtl/core/utf8_to_codepoint_decoder_top.sv
tb/utf8_to_codepoint_decoder_top_test.sv
